// ===== rtl/risc8_pkg.sv =====
// Package: shared types, opcodes and defaults for the risc8 execute stage.
`timescale 1ns / 1ps

package risc8_pkg;

	localparam int REG_COUNT_DEF  = 64;
	localparam int DATA_DEPTH_DEF = 64;

	localparam logic [3:0] OP_ADD  = 4'h0;
	localparam logic [3:0] OP_SUB  = 4'h1;
	localparam logic [3:0] OP_MUL  = 4'h2;
	localparam logic [3:0] OP_MOVI = 4'h3;
	localparam logic [3:0] OP_BEQZ = 4'h4;
	localparam logic [3:0] OP_ANDI = 4'h5;
	localparam logic [3:0] OP_EOR  = 4'h6;
	localparam logic [3:0] OP_BR   = 4'h7;
	localparam logic [3:0] OP_SAL  = 4'h8;
	localparam logic [3:0] OP_SAR  = 4'h9;
	localparam logic [3:0] OP_LDR  = 4'hA;
	localparam logic [3:0] OP_STR  = 4'hB;

	typedef struct packed {
		logic [15:0] instr_word;
		logic [15:0] instr_pc;
	} instr_t;

	typedef struct packed {
		logic        reg_written;
		logic [5:0]  dest_reg;
		logic [7:0]  result_value;
		logic        carry_flag;
		logic        overflow_flag;
		logic        negative_flag;
		logic        sign_flag;
		logic        zero_flag;
		logic        branch_taken;
		logic [15:0] next_pc;
		logic        mem_written;
	} result_t;

	typedef struct packed {
		logic c;
		logic v;
		logic n;
		logic s;
		logic z;
	} flags_t;

endpackage

// ===== rtl/risc8_instruction_execute.sv =====
// Top level: execute stage of the 8-bit RISC machine with register file and data memory.
`timescale 1ns / 1ps
// Pipeline: the accepting edge loads the operand reads into the stage-1 register; when
// stage 1 moves on, it computes, writes back and loads the result register.
// Throughput: one instruction item per cycle, set by the register file and data memory
// ports with write-to-read bypass; back pressure when the result is not taken or while clearing.
// Reset: clears control, flags and register-file valid bits at once, then sweeps the data
// memory to zero, during which no instruction item is accepted.

module risc8_instruction_execute #(
	parameter int REG_COUNT  = risc8_pkg::REG_COUNT_DEF,
	parameter int DATA_DEPTH = risc8_pkg::DATA_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                instr_valid,
	output logic                instr_ready,
	input  risc8_pkg::instr_t   instr,
	output logic                result_valid,
	input  logic                result_ready,
	output risc8_pkg::result_t  result
);

	// Index widths for the register file and the data memory.
	localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int AW = $clog2(DATA_DEPTH);

	// Storage. The register file keeps one valid bit per entry so that reset
	// clears it at once; an entry that was never written reads as zero.
	logic [7:0]           rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] reg_vld_q;
	logic [7:0]           dmem [DATA_DEPTH];

	// Data-memory clearing pass after reset.
	logic                 clr_busy_q;
	logic [AW-1:0]        clr_cnt_q;

	// Stage 1: the accepted instruction and its registered operand reads.
	logic                 vld_s1;
	risc8_pkg::instr_t    instr_s1;
	logic [7:0]           rs_ram_s1;
	logic [7:0]           rt_ram_s1;
	logic                 rs_ok_s1;
	logic                 rt_ok_s1;
	logic                 rs_hit_s1;
	logic                 rt_hit_s1;
	logic [7:0]           reg_byp_s1;
	logic [7:0]           mem_ram_s1;
	logic                 mem_hit_s1;
	logic [7:0]           mem_byp_s1;

	// Result register and architectural flags.
	logic                 res_vld_q;
	risc8_pkg::result_t   res_q;
	risc8_pkg::flags_t    flags_q;

	// Handshake.
	logic                 accept;
	logic                 s1_adv;

	// Read side, driven from the incoming item.
	logic [5:0]           rd_rs;
	logic [5:0]           rd_rt;
	logic [AW-1:0]        rd_maddr;
	logic                 rd_rs_in;
	logic                 rd_rt_in;

	// Stage-1 compute.
	logic [3:0]           op;
	logic [5:0]           rs;
	logic [5:0]           low;
	logic [7:0]           imm;
	logic [7:0]           a_val;
	logic [7:0]           rt_val;
	logic [7:0]           b_val;
	logic [7:0]           mem_val;
	logic [7:0]           res;
	logic                 writes;
	logic                 taken;
	logic                 is_str;
	logic [15:0]          npc;
	logic [8:0]           sum9;
	logic [8:0]           diff9;
	logic [15:0]          prod;
	logic [2:0]           sar_sh;
	risc8_pkg::flags_t    flags_nxt;
	risc8_pkg::result_t   res_nxt;

	// Write back.
	logic                 rs_in_range;
	logic                 reg_we;
	logic [RW-1:0]        reg_widx;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [7:0]           mem_wdata;

	// Stage 1 moves into the result register whenever that register is free or
	// being emptied; a new item enters whenever stage 1 is free or moving on,
	// so items flow one per cycle while the output side keeps taking them.
	assign s1_adv      = vld_s1 && (!res_vld_q || result_ready);
	assign instr_ready = !clr_busy_q && (!vld_s1 || s1_adv);
	assign accept      = instr_valid && instr_ready;

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// Operand addresses taken straight from the incoming item. Registers at or
	// beyond REG_COUNT read as zero.
	assign rd_rs    = instr.instr_word[11:6];
	assign rd_rt    = instr.instr_word[5:0];
	assign rd_maddr = AW'(instr.instr_word[5:0]);
	assign rd_rs_in = {1'b0, rd_rs} < 7'(REG_COUNT);
	assign rd_rt_in = {1'b0, rd_rt} < 7'(REG_COUNT);

	// Register file: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (reg_we) begin
			rf_mem[reg_widx] <= res;
		end
		if (accept) begin
			rs_ram_s1 <= rf_mem[rd_rs[RW-1:0]];
			rt_ram_s1 <= rf_mem[rd_rt[RW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_vld_q <= '0;
		end else if (reg_we) begin
			reg_vld_q[reg_widx] <= 1'b1;
		end
	end

	// Data memory: one write port shared by the clearing pass and STR, one
	// registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			mem_ram_s1 <= dmem[rd_maddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(DATA_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Stage-1 payload and the bypass selects. When the previous item writes
	// back at the same edge that this item reads, the read takes the new value
	// from the bypass instead of the stale array word.
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1   <= instr;
			rs_ok_s1   <= rd_rs_in && reg_vld_q[rd_rs[RW-1:0]];
			rt_ok_s1   <= rd_rt_in && reg_vld_q[rd_rt[RW-1:0]];
			rs_hit_s1  <= reg_we && (rs == rd_rs);
			rt_hit_s1  <= reg_we && (rs == rd_rt);
			reg_byp_s1 <= res;
			mem_hit_s1 <= mem_we && (mem_waddr == rd_maddr);
			mem_byp_s1 <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// Decode and execute.
	always_comb begin
		op     = instr_s1.instr_word[15:12];
		rs     = instr_s1.instr_word[11:6];
		low    = instr_s1.instr_word[5:0];
		imm    = {2'b00, low};

		a_val   = rs_hit_s1 ? reg_byp_s1 : (rs_ok_s1 ? rs_ram_s1 : 8'h00);
		rt_val  = rt_hit_s1 ? reg_byp_s1 : (rt_ok_s1 ? rt_ram_s1 : 8'h00);
		mem_val = mem_hit_s1 ? mem_byp_s1 : mem_ram_s1;

		// Register-register forms take rt from the file, the rest take the
		// zero-extended immediate.
		if (op == risc8_pkg::OP_ADD || op == risc8_pkg::OP_SUB || op == risc8_pkg::OP_MUL ||
		    op == risc8_pkg::OP_EOR || op == risc8_pkg::OP_BR) begin
			b_val = rt_val;
		end else begin
			b_val = imm;
		end

		sum9   = {1'b0, a_val} + {1'b0, b_val};
		// Carry for SUB is bit 8 of the difference of the sign-extended operands.
		diff9  = {a_val[7], a_val} - {b_val[7], b_val};
		prod   = a_val * b_val;
		sar_sh = (b_val >= 8'd7) ? 3'd7 : b_val[2:0];

		res    = 8'h00;
		writes = 1'b1;
		taken  = 1'b0;
		is_str = 1'b0;
		npc    = instr_s1.instr_pc + 16'd1;

		unique case (op)
			risc8_pkg::OP_ADD:  res = sum9[7:0];
			risc8_pkg::OP_SUB:  res = diff9[7:0];
			risc8_pkg::OP_MUL:  res = prod[7:0];
			risc8_pkg::OP_MOVI: res = imm;
			risc8_pkg::OP_ANDI: res = a_val & b_val;
			risc8_pkg::OP_EOR:  res = a_val ^ b_val;
			risc8_pkg::OP_SAL:  res = (b_val >= 8'd8) ? 8'h00 : (a_val << b_val[2:0]);
			risc8_pkg::OP_SAR:  res = 8'($signed(a_val) >>> sar_sh);
			risc8_pkg::OP_LDR:  res = mem_val;
			risc8_pkg::OP_STR: begin
				writes = 1'b0;
				is_str = 1'b1;
			end
			risc8_pkg::OP_BEQZ: begin
				writes = 1'b0;
				if (a_val == 8'h00) begin
					taken = 1'b1;
					npc   = instr_s1.instr_pc + 16'd1 + 16'(imm);
				end
			end
			risc8_pkg::OP_BR: begin
				writes = 1'b0;
				taken  = 1'b1;
				npc    = {a_val, b_val};
			end
			default: writes = 1'b0;
		endcase

		// Every register-writing operation rebuilds the flags from scratch;
		// only ADD and SUB produce carry, overflow and sign.
		flags_nxt = flags_q;
		if (writes) begin
			flags_nxt   = '0;
			flags_nxt.z = (res == 8'h00);
			flags_nxt.n = res[7];
			if (op == risc8_pkg::OP_ADD) begin
				flags_nxt.c = sum9[8];
				flags_nxt.v = ((a_val[7] ^ res[7]) & (b_val[7] ^ res[7]));
				flags_nxt.s = flags_nxt.n ^ flags_nxt.v;
			end else if (op == risc8_pkg::OP_SUB) begin
				flags_nxt.c = diff9[8];
				flags_nxt.v = ((a_val[7] ^ b_val[7]) & (a_val[7] ^ res[7]));
				flags_nxt.s = flags_nxt.n ^ flags_nxt.v;
			end
		end

		rs_in_range = {1'b0, rs} < 7'(REG_COUNT);

		res_nxt               = '0;
		res_nxt.reg_written   = writes && (rs != 6'd0) && rs_in_range;
		res_nxt.dest_reg      = rs;
		res_nxt.result_value  = writes ? res : 8'h00;
		res_nxt.carry_flag    = flags_nxt.c;
		res_nxt.overflow_flag = flags_nxt.v;
		res_nxt.negative_flag = flags_nxt.n;
		res_nxt.sign_flag     = flags_nxt.s;
		res_nxt.zero_flag     = flags_nxt.z;
		res_nxt.branch_taken  = taken;
		res_nxt.next_pc       = npc;
		// With the default DATA_DEPTH of 64, every immediate address is in range.
		res_nxt.mem_written   = is_str;
	end

	// Write back happens at the edge where stage 1 moves into the result register.
	assign reg_we    = s1_adv && res_nxt.reg_written;
	assign reg_widx  = rs[RW-1:0];
	assign mem_we    = clr_busy_q || (s1_adv && is_str);
	assign mem_waddr = clr_busy_q ? clr_cnt_q : AW'(low);
	assign mem_wdata = clr_busy_q ? 8'h00 : a_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				flags_q   <= flags_nxt;
				res_vld_q <= 1'b1;
			end else if (result_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_nxt;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !instr_ready)
		else $error("instruction accepted during data memory clearing pass");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_adv) |=> (vld_s1 && $stable(instr_s1)))
		else $error("stalled stage-1 item lost or changed");

	a_r0_never_written: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.reg_written) |-> (result.dest_reg != 6'd0))
		else $error("write reported for register zero");

	a_branch_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.branch_taken) |->
		(!result.reg_written && !result.mem_written && result.result_value == 8'h00))
		else $error("taken branch also wrote state");

	a_store_no_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.mem_written) |-> !result.reg_written)
		else $error("store also wrote a register");
`endif

endmodule

// ===== tb/sv/risc8_exec_checker.sv =====
// Checker for the risc8 execute stage: predicts each result item and compares it.
`timescale 1ns / 1ps

module risc8_exec_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               instr_valid,
	input  logic               instr_ready,
	input  risc8_pkg::instr_t  instr,
	input  logic               result_valid,
	input  logic               result_ready,
	input  risc8_pkg::result_t result,
	output int                 mismatches,
	output int                 outstanding
);

	logic [7:0]         gpr  [risc8_pkg::REG_COUNT_DEF];
	logic [7:0]         dmem [risc8_pkg::DATA_DEPTH_DEF];
	risc8_pkg::flags_t  status;
	risc8_pkg::result_t expected_results [$];

	initial mismatches = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Runs one instruction against the shadow register file, flags and data memory.
	function automatic risc8_pkg::result_t execute_instr(input risc8_pkg::instr_t it);
		logic [3:0]         op;
		logic [5:0]         rs;
		logic [5:0]         low;
		logic               uses_rt;
		logic               writes;
		logic [7:0]         a;
		logic [7:0]         b;
		logic [7:0]         res;
		logic [8:0]         sum;
		logic [15:0]        diff;
		risc8_pkg::result_t r;
		op      = it.instr_word[15:12];
		rs      = it.instr_word[11:6];
		low     = it.instr_word[5:0];
		uses_rt = op inside {risc8_pkg::OP_ADD, risc8_pkg::OP_SUB, risc8_pkg::OP_MUL,
			risc8_pkg::OP_EOR, risc8_pkg::OP_BR};
		a       = gpr[rs];
		b       = uses_rt ? gpr[low] : {2'b00, low};
		res     = '0;
		writes  = 1'b1;
		r          = '0;
		r.dest_reg = rs;
		r.next_pc  = it.instr_pc + 16'd1;
		case (op)
		risc8_pkg::OP_ADD:  res = a + b;
		risc8_pkg::OP_SUB:  res = a - b;
		risc8_pkg::OP_MUL:  res = a * b;
		risc8_pkg::OP_MOVI: res = b;
		risc8_pkg::OP_ANDI: res = a & b;
		risc8_pkg::OP_EOR:  res = a ^ b;
		risc8_pkg::OP_SAL:  res = (b >= 8'd8) ? 8'h00 : (a << b);
		risc8_pkg::OP_SAR:  res = $signed(a) >>> ((b >= 8'd7) ? 8'd7 : b);
		risc8_pkg::OP_LDR:  res = dmem[low];
		risc8_pkg::OP_STR: begin
			writes        = 1'b0;
			dmem[low]     = a;
			r.mem_written = 1'b1;
		end
		risc8_pkg::OP_BEQZ: begin
			writes = 1'b0;
			if (a == 8'h00) begin
				r.branch_taken = 1'b1;
				r.next_pc      = it.instr_pc + 16'd1 + {10'd0, low};
			end
		end
		risc8_pkg::OP_BR: begin
			writes         = 1'b0;
			r.branch_taken = 1'b1;
			r.next_pc      = {a, b};
		end
		default: writes = 1'b0;
		endcase
		if (writes) begin
			if (rs != 6'd0) begin
				gpr[rs]       = res;
				r.reg_written = 1'b1;
			end
			status   = '0;
			status.z = (res == 8'h00);
			status.n = res[7];
			if (op == risc8_pkg::OP_ADD) begin
				sum      = {1'b0, a} + {1'b0, b};
				status.c = sum[8];
				status.v = (a[7] ^ res[7]) & (b[7] ^ res[7]);
			end
			if (op == risc8_pkg::OP_SUB) begin
				// Carry is taken from the difference of the sign-extended operands.
				diff     = {{8{a[7]}}, a} - {{8{b[7]}}, b};
				status.c = diff[8];
				status.v = (a[7] ^ b[7]) & (a[7] ^ res[7]);
			end
			if (op == risc8_pkg::OP_ADD || op == risc8_pkg::OP_SUB)
				status.s = status.n ^ status.v;
			r.result_value = res;
		end
		r.carry_flag    = status.c;
		r.overflow_flag = status.v;
		r.negative_flag = status.n;
		r.sign_flag     = status.s;
		r.zero_flag     = status.z;
		return r;
	endfunction

	task automatic compare_result(input risc8_pkg::result_t want,
			input risc8_pkg::result_t got);
		if (got.reg_written !== want.reg_written)
			report_mismatch($sformatf("reg_written %b, expected %b",
				got.reg_written, want.reg_written));
		if (got.dest_reg !== want.dest_reg)
			report_mismatch($sformatf("dest_reg %0d, expected %0d",
				got.dest_reg, want.dest_reg));
		if (got.result_value !== want.result_value)
			report_mismatch($sformatf("result_value %h, expected %h",
				got.result_value, want.result_value));
		if (got.carry_flag !== want.carry_flag)
			report_mismatch($sformatf("carry_flag %b, expected %b",
				got.carry_flag, want.carry_flag));
		if (got.overflow_flag !== want.overflow_flag)
			report_mismatch($sformatf("overflow_flag %b, expected %b",
				got.overflow_flag, want.overflow_flag));
		if (got.negative_flag !== want.negative_flag)
			report_mismatch($sformatf("negative_flag %b, expected %b",
				got.negative_flag, want.negative_flag));
		if (got.sign_flag !== want.sign_flag)
			report_mismatch($sformatf("sign_flag %b, expected %b",
				got.sign_flag, want.sign_flag));
		if (got.zero_flag !== want.zero_flag)
			report_mismatch($sformatf("zero_flag %b, expected %b",
				got.zero_flag, want.zero_flag));
		if (got.branch_taken !== want.branch_taken)
			report_mismatch($sformatf("branch_taken %b, expected %b",
				got.branch_taken, want.branch_taken));
		if (got.next_pc !== want.next_pc)
			report_mismatch($sformatf("next_pc %h, expected %h",
				got.next_pc, want.next_pc));
		if (got.mem_written !== want.mem_written)
			report_mismatch($sformatf("mem_written %b, expected %b",
				got.mem_written, want.mem_written));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (gpr[i])
				gpr[i] = '0;
			foreach (dmem[i])
				dmem[i] = '0;
			status = '0;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (instr_valid && instr_ready)
				expected_results.push_back(execute_instr(instr));
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0)
					report_mismatch("result item with no instruction waiting for it");
				else
					compare_result(expected_results.pop_front(), result);
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_risc8_instruction_execute.sv =====
// Testbench top for the risc8 execute stage: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_risc8_instruction_execute;

	// Opcodes 12 to 15 are unused by the machine and must leave all state alone.
	localparam logic [3:0] OP_RSVD_LO = 4'hC;
	localparam logic [3:0] OP_RSVD_HI = 4'hF;

	localparam int RANDOM_ITEMS = 1500;
	// Quiet cycles allowed before the run is declared hung. The slowest legal quiet
	// stretch is the memory-clearing sweep after reset or the long result hold-off.
	localparam int STALL_LIMIT  = 2000;
	localparam int LONG_HOLD    = 150;
	localparam int DRAIN_CYCLES = 10;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               instr_valid  = 1'b0;
	risc8_pkg::instr_t  instr        = '0;
	logic               result_ready = 1'b0;
	logic               instr_ready;
	logic               result_valid;
	risc8_pkg::result_t result;

	int mismatches;
	int outstanding;
	int quiet_cycles = 0;

	// Shared between the stimulus and the result sink: idle_on enables random
	// bursts on both sides, hold_req asks the sink for one long hold-off.
	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;

	risc8_instruction_execute uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_ready  (instr_ready),
		.instr        (instr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	risc8_exec_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_ready  (instr_ready),
		.instr        (instr),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Offers one instruction item and holds it until the block takes it. When idling
	// is enabled, a random gap may come first. The task returns in the time step of
	// the accepting edge, so the next item can follow back to back.
	task automatic send_instr(input logic [3:0] op, input logic [5:0] rs,
			input logic [5:0] low, input logic [15:0] pc);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			instr_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		instr       <= {op, rs, low, pc};
		instr_valid <= 1'b1;
		do
			@(posedge clk);
		while (instr_ready !== 1'b1);
	endtask

	// Result side. Each pass drives result_ready once and then waits on the clock before
	// the next pass, so there is never more than one assignment per time step.
	initial begin : result_sink
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// Long hold-off: the block fills up and has to stall its input.
				hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Hang detection: any handshake on either side counts as progress.
	always @(posedge clk) begin
		if ((instr_valid && instr_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int         i;
		logic [3:0] op;
		logic [5:0] rs;
		logic [5:0] low;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The register file starts cleared, so the values below are
		// built up step by step and each line relies on the ones before it.
		send_instr(risc8_pkg::OP_MOVI, 6'd1, 6'd63, 16'h0000);  // largest immediate
		// R0 stays zero, flags still move.
		send_instr(risc8_pkg::OP_MOVI, 6'd0, 6'd63, 16'h1234);
		send_instr(risc8_pkg::OP_ADD, 6'd1, 6'd1, 16'h0002);  // 63 + 63 = 126
		send_instr(risc8_pkg::OP_ADD, 6'd1, 6'd1, 16'h0003);  // 126 + 126: signed overflow
		send_instr(risc8_pkg::OP_ADD, 6'd1, 6'd1, 16'h0004);  // 252 + 252: carry out
		send_instr(risc8_pkg::OP_MOVI, 6'd2, 6'd1, 16'h0005);
		send_instr(risc8_pkg::OP_SUB, 6'd3, 6'd2, 16'h0006);  // 0 - 1: signed borrow, carry
		send_instr(risc8_pkg::OP_MOVI, 6'd4, 6'd1, 16'h0007);
		send_instr(risc8_pkg::OP_SAL, 6'd4, 6'd7, 16'h0008);  // 0x80, most negative value
		send_instr(risc8_pkg::OP_SUB, 6'd4, 6'd2, 16'h0009);  // 0x80 - 1: subtract overflow
		send_instr(risc8_pkg::OP_ADD, 6'd4, 6'd2, 16'h000A);  // 0x7F + 1: add overflow
		send_instr(risc8_pkg::OP_SAR, 6'd4, 6'd3, 16'h000B);  // sign fills from the left
		send_instr(risc8_pkg::OP_SAR, 6'd4, 6'd63, 16'h000C);  // long right shift stops at 7
		send_instr(risc8_pkg::OP_SAL, 6'd4, 6'd8, 16'h000D);  // long left shift gives zero
		send_instr(risc8_pkg::OP_MUL, 6'd1, 6'd1, 16'h000E);
		send_instr(risc8_pkg::OP_EOR, 6'd1, 6'd1, 16'h000F);  // self xor clears, sets Z
		send_instr(risc8_pkg::OP_ANDI, 6'd3, 6'd63, 16'h0010);
		send_instr(risc8_pkg::OP_STR, 6'd3, 6'd63, 16'h0011);  // top data address
		send_instr(risc8_pkg::OP_LDR, 6'd6, 6'd63, 16'h0012);  // reads back the store
		send_instr(risc8_pkg::OP_LDR, 6'd7, 6'd0, 16'h0013);  // untouched memory reads zero
		// Taken, and the target wraps past 0xFFFF.
		send_instr(risc8_pkg::OP_BEQZ, 6'd1, 6'd63, 16'hFFFF);
		// Not taken, and pc + 1 wraps to 0.
		send_instr(risc8_pkg::OP_BEQZ, 6'd3, 6'd0, 16'hFFFF);
		send_instr(risc8_pkg::OP_BR, 6'd3, 6'd2, 16'h0016);  // target from two register bytes
		send_instr(OP_RSVD_HI, 6'd63, 6'd63, 16'h0000);  // all-ones word, unused opcode
		send_instr(OP_RSVD_LO, 6'd0,  6'd0,  16'h5555);

		// Let the directed part drain completely before the random part.
		instr_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);

		// Random part. Register and shift fields lean toward small values so that
		// instructions depend on each other and short shifts are common; a tenth of
		// the items use the unused opcodes.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			// Idling comes and goes in blocks of items and stops for the final stretch.
			idle_on = (i < RANDOM_ITEMS - 200) && ((i / 250) % 3 != 2);
			if (i == 100)
				hold_req = 1'b1;
			if (i == 700) begin
				// Sender pause until every expected result has come back.
				instr_valid <= 1'b0;
				@(posedge clk);
				wait (outstanding == 0);
				@(posedge clk);
			end
			if ($urandom_range(0, 9) == 0)
				op = 4'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
			else
				op = 4'($urandom_range(risc8_pkg::OP_ADD, risc8_pkg::OP_STR));
			rs  = 6'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63));
			low = 6'($urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom_range(0, 63));
			send_instr(op, rs, low, 16'($urandom()));
		end

		instr_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		// Waiting DRAIN_CYCLES more catches any result item the block sends without cause.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/risc8_pkg.sv
rtl/risc8_instruction_execute.sv
tb/sv/risc8_exec_checker.sv
tb/sv/tb_risc8_instruction_execute.sv
